### src/touch_gesture_classifier_defines.svh
// Assertion macros used by the core RTL file, tgc_core.sv.
`ifndef TOUCH_GESTURE_CLASSIFIER_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checks that a condition implies another in the same cycle.
`define TGC_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// Checks that a condition implies another in the cycle after it.
`define TGC_ASSERT_NXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define TGC_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define TGC_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif

`endif

### src/tgc_pkg.sv
`default_nettype none

package tgc_pkg;

	localparam int ZONES      = 8;
	localparam int MASK_W     = 8;
	localparam int TS_W       = 32;
	localparam int TIME_W     = 16;
	localparam int RUN_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;

	// Zones beyond ZONES are ignored.
	localparam logic [MASK_W-1:0] ZONE_EN = (ZONES >= MASK_W) ? {MASK_W{1'b1}} :
		MASK_W'((64'd1 << ZONES) - 64'd1);

	localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TAP_MAX    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DTAP_WIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STROKE_WIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_LEN    = 3'd5;

	typedef enum logic [2:0] {
		G_NONE   = 3'd0,
		G_TAP    = 3'd1,
		G_DOUBLE = 3'd2,
		G_LONG   = 3'd3,
		G_HOLD   = 3'd4,
		G_STROKE = 3'd5,
		G_REPEAT = 3'd6
	} gesture_t;

	typedef struct packed {
		logic [TIME_W-1:0] tap_max_time;
		logic [TIME_W-1:0] double_tap_window;
		logic [TIME_W-1:0] long_press_time;
		logic [TIME_W-1:0] hold_time;
		logic [TIME_W-1:0] stroke_window;
		logic [RUN_W-1:0]  stroke_run_length;
	} cfg_t;

	typedef struct packed {
		logic     busy;
		gesture_t second;
		gesture_t first;
	} result_t;

	// Time difference read as a signed 32-bit value, compared with an unsigned threshold.
	function automatic logic tdiff_le(input logic [TS_W-1:0] d, input logic [TIME_W-1:0] thr);
		return $signed(d) <= $signed({{(TS_W-TIME_W){1'b0}}, thr});
	endfunction

	function automatic logic tdiff_ge(input logic [TS_W-1:0] d, input logic [TIME_W-1:0] thr);
		return $signed(d) >= $signed({{(TS_W-TIME_W){1'b0}}, thr});
	endfunction

endpackage

`default_nettype wire

### src/tgc_cfg.sv
`default_nettype none

module tgc_cfg (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [tgc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire [tgc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output tgc_pkg::cfg_t                cfg
);
	import tgc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_max_time      <= 16'd250;
			cfg_q.double_tap_window <= 16'd400;
			cfg_q.long_press_time   <= 16'd700;
			cfg_q.hold_time         <= 16'd1500;
			cfg_q.stroke_window     <= 16'd1200;
			cfg_q.stroke_run_length <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TAP_MAX:    cfg_q.tap_max_time      <= cfg_wdata;
				REG_DTAP_WIN:   cfg_q.double_tap_window <= cfg_wdata;
				REG_LONG_TIME:  cfg_q.long_press_time   <= cfg_wdata;
				REG_HOLD_TIME:  cfg_q.hold_time         <= cfg_wdata;
				REG_STROKE_WIN: cfg_q.stroke_window     <= cfg_wdata;
				REG_RUN_LEN:    cfg_q.stroke_run_length <= cfg_wdata[RUN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### src/tgc_core.sv
`default_nettype none

`include "touch_gesture_classifier_defines.svh"

module tgc_core (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       en,
	input  wire [tgc_pkg::MASK_W-1:0] zone_mask,
	input  wire [tgc_pkg::TS_W-1:0]   timestamp,
	input  wire tgc_pkg::cfg_t        cfg,
	output tgc_pkg::result_t          res
);
	import tgc_pkg::*;

	logic              contact_active_q, long_reported_q, hold_reported_q, tap_waiting_q;
	logic [TS_W-1:0]   contact_start_q, tap_time_q, last_stroke_q;
	logic [MASK_W-1:0] zones_seen_q;
	logic [RUN_W-1:0]  stroke_run_q;

	logic              contact_active_d, long_reported_d, hold_reported_d, tap_waiting_d;
	logic [TS_W-1:0]   contact_start_d, tap_time_d, last_stroke_d;
	logic [MASK_W-1:0] zones_seen_d;
	logic [RUN_W-1:0]  stroke_run_d;

	logic [MASK_W-1:0] mask;
	logic              active, multi, do_stroke;
	logic [TS_W-1:0]   dur;
	logic [RUN_W-1:0]  run;
	gesture_t          ev_long, ev_hold, ev_rel, ev_tap, g0, g1;
	gesture_t          evs [4];
	logic              tap_out, repeat_out;

	always_comb begin
		contact_active_d = contact_active_q;
		long_reported_d  = long_reported_q;
		hold_reported_d  = hold_reported_q;
		tap_waiting_d    = tap_waiting_q;
		contact_start_d  = contact_start_q;
		tap_time_d       = tap_time_q;
		last_stroke_d    = last_stroke_q;
		zones_seen_d     = zones_seen_q;
		stroke_run_d     = stroke_run_q;

		mask      = zone_mask & ZONE_EN;
		active    = |mask;
		dur       = timestamp - contact_start_q;
		multi     = (zones_seen_q & (zones_seen_q - 1'b1)) != '0;
		do_stroke = 1'b0;
		run       = stroke_run_q;
		ev_long   = G_NONE;
		ev_hold   = G_NONE;
		ev_rel    = G_NONE;
		ev_tap    = G_NONE;

		if (active && !contact_active_q) begin
			contact_active_d = 1'b1;
			contact_start_d  = timestamp;
			zones_seen_d     = mask;
			long_reported_d  = 1'b0;
			hold_reported_d  = 1'b0;
		end else if (active) begin
			zones_seen_d = zones_seen_q | mask;
			if (!long_reported_q && tdiff_ge(dur, cfg.long_press_time)) begin
				long_reported_d = 1'b1;
				ev_long         = G_LONG;
			end
			if (!hold_reported_q && tdiff_ge(dur, cfg.hold_time)) begin
				hold_reported_d = 1'b1;
				ev_hold         = G_HOLD;
			end
		end else if (contact_active_q) begin
			contact_active_d = 1'b0;
			zones_seen_d     = '0;
			// A contact that already gave a long press is not classified again.
			if (!long_reported_q) begin
				if (multi) begin
					do_stroke = 1'b1;
				end else if (tdiff_le(dur, cfg.tap_max_time)) begin
					if (tap_waiting_q &&
					    tdiff_le(timestamp - tap_time_q, cfg.double_tap_window)) begin
						tap_waiting_d = 1'b0;
						ev_rel        = G_DOUBLE;
					end else begin
						tap_waiting_d = 1'b1;
						tap_time_d    = timestamp;
					end
				end else begin
					do_stroke = 1'b1;
				end
			end
		end

		if (do_stroke) begin
			if (tdiff_le(timestamp - last_stroke_q, cfg.stroke_window)) begin
				run = (stroke_run_q == RUN_MAX) ? stroke_run_q : stroke_run_q + 1'b1;
			end else begin
				run = RUN_W'(1);
			end
			last_stroke_d = timestamp;
			if (cfg.stroke_run_length != '0 && run >= cfg.stroke_run_length) begin
				stroke_run_d = '0;
				ev_rel       = G_REPEAT;
			end else begin
				stroke_run_d = run;
				ev_rel       = G_STROKE;
			end
		end

		// A pending tap is flushed once its window has lapsed with no contact held.
		if (!contact_active_d && tap_waiting_d &&
		    !tdiff_le(timestamp - tap_time_d, cfg.double_tap_window)) begin
			tap_waiting_d = 1'b0;
			ev_tap        = G_TAP;
		end

		evs[0] = ev_long;
		evs[1] = ev_hold;
		evs[2] = ev_rel;
		evs[3] = ev_tap;
		g0 = G_NONE;
		g1 = G_NONE;
		for (int i = 0; i < 4; i++) begin
			if (evs[i] != G_NONE) begin
				if (g0 == G_NONE) begin
					g0 = evs[i];
				end else if (g1 == G_NONE) begin
					g1 = evs[i];
				end
			end
		end
	end

	assign res.first  = g0;
	assign res.second = g1;
	assign res.busy   = contact_active_d | tap_waiting_d;

	assign tap_out    = (res.first == G_TAP) || (res.second == G_TAP);
	assign repeat_out = (res.first == G_REPEAT) || (res.second == G_REPEAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contact_active_q <= 1'b0;
			long_reported_q  <= 1'b0;
			hold_reported_q  <= 1'b0;
			tap_waiting_q    <= 1'b0;
			contact_start_q  <= '0;
			tap_time_q       <= '0;
			last_stroke_q    <= '0;
			zones_seen_q     <= '0;
			stroke_run_q     <= '0;
		end else if (en) begin
			contact_active_q <= contact_active_d;
			long_reported_q  <= long_reported_d;
			hold_reported_q  <= hold_reported_d;
			tap_waiting_q    <= tap_waiting_d;
			contact_start_q  <= contact_start_d;
			tap_time_q       <= tap_time_d;
			last_stroke_q    <= last_stroke_d;
			zones_seen_q     <= zones_seen_d;
			stroke_run_q     <= stroke_run_d;
		end
	end

	`TGC_ASSERT_IMP(a_second_after_first, clk, arst_n, res.second != G_NONE, res.first != G_NONE)
	`TGC_ASSERT_IMP(a_zones_clear_idle, clk, arst_n, !contact_active_q, zones_seen_q == '0)
	`TGC_ASSERT_NXT(a_long_marks, clk, arst_n, en && res.first == G_LONG, long_reported_q)
	`TGC_ASSERT_NXT(a_tap_clears, clk, arst_n, en && tap_out, !tap_waiting_q)
	`TGC_ASSERT_NXT(a_repeat_resets_run, clk, arst_n, en && repeat_out, stroke_run_q == '0)

endmodule

`default_nettype wire

### src/touch_gesture_classifier.sv
// Channel    Direction  Handshake            Payload
// s_axis     in         s_tvalid / s_tready  s_tdata: zone_mask, timestamp (40 bits)
// m_axis     out        m_tvalid / m_tready  m_tdata: first/second gesture, busy (8 bits)
// cfg        in         cfg_we               cfg_idx, cfg_wdata (no read-back)
//
// One poll per clock cycle sustained while m_tready holds; a result passes the input register and is then
// registered in the output register. The classification state loop closes combinationally between the input and the
// state registers, so consecutive items see each other's updates.
// Reset is asynchronous, clears the valid flags and the classifier state and restores the default settings;
// the data registers are loaded only when an item moves.
// A stalled result stays in the output register while one more item waits at the input.
`default_nettype none

module touch_gesture_classifier (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	// [7:0] zone_mask, [39:8] timestamp
	input  wire [tgc_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	// [2:0] first_gesture, [5:3] second_gesture, [6] busy_res, [7] zero
	output logic [tgc_pkg::OUT_DATA_W-1:0] m_tdata,
	input  wire                            cfg_we,
	input  wire [tgc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire [tgc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import tgc_pkg::*;

	logic              valid_s1;
	logic [MASK_W-1:0] zone_mask_s1;
	logic [TS_W-1:0]   timestamp_s1;
	logic              out_valid_q;
	result_t           res_q;
	result_t           res;
	cfg_t              cfg;
	logic              advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	tgc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tgc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.zone_mask (zone_mask_s1),
		.timestamp (timestamp_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			zone_mask_s1 <= s_tdata[MASK_W-1:0];
			timestamp_s1 <= s_tdata[MASK_W+TS_W-1:MASK_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q.busy, res_q.second, res_q.first};

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import tgc_pkg::*;

	// Indexes that decode to no register; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// [7:0] zone_mask, [39:8] timestamp
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// [2:0] first_gesture, [5:3] second_gesture, [6] busy_res, [7] zero
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	touch_gesture_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	logic [IN_DATA_W-1:0] poll_queue[$];
	result_t              gesture_expect[$];
	int                   mismatches = 0;
	logic                 in_taken   = 1'b0;
	int                   gap_left   = 0;
	int                   stall_left = 0;
	bit                   drain_wait = 1'b0;
	bit                   calm       = 1'b0;
	logic [TS_W-1:0]      now_ms     = '0;

	// Classifier state as the block should hold it.
	cfg_t              mdl_cfg;
	logic              contact_on, long_done, hold_done, tap_pending;
	logic [TS_W-1:0]   contact_t0, tap_t0, prev_stroke_at;
	logic [MASK_W-1:0] zones_touched;
	logic [RUN_W-1:0]  stroke_run;
	gesture_t          ev_first, ev_second;
	int                ev_count;

	function automatic logic signed [TS_W-1:0] elapsed(input logic [TS_W-1:0] a,
			input logic [TS_W-1:0] b);
		return a - b;
	endfunction

	function automatic logic signed [TS_W-1:0] as_limit(input logic [TIME_W-1:0] v);
		return $signed({{(TS_W-TIME_W){1'b0}}, v});
	endfunction

	task automatic emit(input gesture_t g);
		if (ev_count == 0)
			ev_first = g;
		else if (ev_count == 1)
			ev_second = g;
		if (ev_count < 2)
			ev_count++;
	endtask

	task automatic record_stroke(input logic [TS_W-1:0] ts);
		if (elapsed(ts, prev_stroke_at) <= as_limit(mdl_cfg.stroke_window)) begin
			if (stroke_run != RUN_MAX)
				stroke_run++;
		end else begin
			stroke_run = RUN_W'(1);
		end
		prev_stroke_at = ts;
		if (mdl_cfg.stroke_run_length != 0 && stroke_run >= mdl_cfg.stroke_run_length) begin
			stroke_run = '0;
			emit(G_REPEAT);
		end else begin
			emit(G_STROKE);
		end
	endtask

	task automatic release_contact(input logic [TS_W-1:0] ts);
		logic signed [TS_W-1:0] held_for;
		logic                   multi;
		held_for = elapsed(ts, contact_t0);
		multi = (zones_touched & (zones_touched - 8'd1)) != 0;
		contact_on = 1'b0;
		zones_touched = '0;
		// A contact that already gave a long press ends silently.
		if (!long_done) begin
			if (multi) begin
				record_stroke(ts);
			end else if (held_for <= as_limit(mdl_cfg.tap_max_time)) begin
				if (tap_pending &&
						elapsed(ts, tap_t0) <= as_limit(mdl_cfg.double_tap_window)) begin
					tap_pending = 1'b0;
					emit(G_DOUBLE);
				end else begin
					tap_pending = 1'b1;
					tap_t0 = ts;
				end
			end else begin
				record_stroke(ts);
			end
		end
	endtask

	task automatic classify_poll(input logic [MASK_W-1:0] raw_mask, input logic [TS_W-1:0] ts,
			output result_t res);
		logic [MASK_W-1:0]      mask;
		logic signed [TS_W-1:0] held_for;
		mask = raw_mask & ZONE_EN;
		ev_count = 0;
		ev_first = G_NONE;
		ev_second = G_NONE;
		if (mask != 0 && !contact_on) begin
			contact_on = 1'b1;
			contact_t0 = ts;
			zones_touched = mask;
			long_done = 1'b0;
			hold_done = 1'b0;
		end else if (mask != 0) begin
			held_for = elapsed(ts, contact_t0);
			zones_touched |= mask;
			if (!long_done && held_for >= as_limit(mdl_cfg.long_press_time)) begin
				long_done = 1'b1;
				emit(G_LONG);
			end
			if (!hold_done && held_for >= as_limit(mdl_cfg.hold_time)) begin
				hold_done = 1'b1;
				emit(G_HOLD);
			end
		end else if (contact_on) begin
			release_contact(ts);
		end
		if (!contact_on && tap_pending &&
				elapsed(ts, tap_t0) > as_limit(mdl_cfg.double_tap_window)) begin
			tap_pending = 1'b0;
			emit(G_TAP);
		end
		res.first = ev_first;
		res.second = ev_second;
		res.busy = contact_on || tap_pending;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Poll driver: a new item may replace an accepted one in the same step.
	always @(negedge clk) begin : poll_driver
		logic                 next_valid;
		logic [IN_DATA_W-1:0] next_data;
		next_valid = s_tvalid;
		next_data = s_tdata;
		if (s_tvalid && in_taken)
			next_valid = 1'b0;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (!next_valid) begin
			if (drain_wait) begin
				if (gesture_expect.size() == 0)
					drain_wait = 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (poll_queue.size() > 0) begin
				next_data = poll_queue.pop_front();
				next_valid = 1'b1;
				gap_left = calm ? 0 : pick_gap();
				if ($urandom_range(0, 149) == 0)
					drain_wait = 1'b1;
			end
		end
		s_tvalid <= next_valid;
		s_tdata <= next_data;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!calm && $urandom_range(0, 5) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin : monitor
		result_t want, got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (gesture_expect.size() == 0) begin
					$error("result item with no poll waiting: %h", m_tdata);
					mismatches++;
				end else begin
					want = gesture_expect.pop_front();
					got = result_t'(m_tdata[6:0]);
					if (got.first !== want.first) begin
						$error("first_gesture: expected %0d, got %0d", want.first, got.first);
						mismatches++;
					end
					if (got.second !== want.second) begin
						$error("second_gesture: expected %0d, got %0d", want.second, got.second);
						mismatches++;
					end
					if (got.busy !== want.busy) begin
						$error("busy_res: expected %0d, got %0d", want.busy, got.busy);
						mismatches++;
					end
					if (m_tdata[7] !== 1'b0) begin
						$error("pad: expected 0, got %b", m_tdata[7]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				classify_poll(s_tdata[7:0], s_tdata[39:8], want);
				gesture_expect.push_back(want);
			end
			in_taken <= s_tvalid && s_tready;
		end else begin
			in_taken <= 1'b0;
		end
	end

	task automatic queue_poll(input logic [MASK_W-1:0] mask, input logic [TS_W-1:0] ts);
		poll_queue.push_back({ts, mask});
	endtask

	// One contact of the given length: held polls spread over it, then a release.
	task automatic add_contact(input int dur, input int held, input bit multi);
		logic [TS_W-1:0]   start;
		logic [MASK_W-1:0] zone, mask;
		int                k, s;
		start = now_ms;
		zone = 8'h01 << $urandom_range(0, 7);
		for (k = 0; k < held; k++) begin
			mask = zone;
			if (multi && k == held - 1) begin
				s = $urandom_range(1, 7);
				mask = zone | (zone << s) | (zone >> (8 - s));
				if ($urandom_range(0, 3) == 0)
					mask |= 8'($urandom());
			end
			queue_poll(mask, start + TS_W'((longint'(dur) * k) / held));
		end
		now_ms = start + TS_W'(dur);
		queue_poll(8'h00, now_ms);
	endtask

	task automatic add_sequence();
		int tmax, dwin, lp, hd, sw, n, k;
		tmax = mdl_cfg.tap_max_time;
		dwin = mdl_cfg.double_tap_window;
		lp = mdl_cfg.long_press_time;
		hd = mdl_cfg.hold_time;
		sw = mdl_cfg.stroke_window;
		case ($urandom_range(0, 9))
			0, 1: begin
				add_contact($urandom_range(0, tmax), $urandom_range(1, 3), 1'b0);
			end
			2: begin
				add_contact($urandom_range(0, tmax), $urandom_range(1, 2), 1'b0);
				now_ms += $urandom_range(0, dwin);
				add_contact($urandom_range(0, tmax), $urandom_range(1, 2), 1'b0);
			end
			3: begin
				add_contact($urandom_range(lp, (lp > hd ? lp : hd) + 100), $urandom_range(2, 8),
					$urandom_range(0, 3) == 0);
			end
			4: begin
				add_contact($urandom_range(tmax + 1, tmax + 1 + lp), $urandom_range(1, 4), 1'b0);
			end
			5: begin
				add_contact($urandom_range(0, lp), $urandom_range(1, 4), 1'b1);
			end
			6: begin
				n = $urandom_range(2, 6);
				for (k = 0; k < n; k++) begin
					add_contact($urandom_range(0, tmax), $urandom_range(1, 2), 1'b1);
					now_ms += $urandom_range(0, sw + sw / 8 + 2);
				end
			end
			7: begin
				n = $urandom_range(1, 3);
				for (k = 0; k < n; k++) begin
					now_ms += $urandom_range(0, 2 * dwin + 2);
					queue_poll(8'h00, now_ms);
				end
			end
			8: begin
				// Noise: arbitrary masks, time jumps and time running backwards.
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++) begin
					case ($urandom_range(0, 3))
						0: now_ms = $urandom();
						1: now_ms -= $urandom_range(0, 2000);
						default: now_ms += $urandom_range(0, 300);
					endcase
					queue_poll(8'($urandom_range(0, 255)), now_ms);
				end
			end
			default: begin
				// A tap left pending, then a stroke released after its window.
				add_contact($urandom_range(0, tmax), 1, 1'b0);
				now_ms += $urandom_range(dwin, dwin + 200);
				add_contact($urandom_range(0, lp), $urandom_range(1, 2), 1'b1);
			end
		endcase
		now_ms += $urandom_range(0, dwin + 50);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_TAP_MAX:    mdl_cfg.tap_max_time = val;
			REG_DTAP_WIN:   mdl_cfg.double_tap_window = val;
			REG_LONG_TIME:  mdl_cfg.long_press_time = val;
			REG_HOLD_TIME:  mdl_cfg.hold_time = val;
			REG_STROKE_WIN: mdl_cfg.stroke_window = val;
			REG_RUN_LEN:    mdl_cfg.stroke_run_length = val[RUN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input int tmax, input int dwin, input int lp, input int hd,
			input int sw, input logic [CFG_DATA_W-1:0] run_word);
		write_reg(REG_TAP_MAX, 16'(tmax));
		write_reg(REG_DTAP_WIN, 16'(dwin));
		write_reg(REG_LONG_TIME, 16'(lp));
		write_reg(REG_HOLD_TIME, 16'(hd));
		write_reg(REG_STROKE_WIN, 16'(sw));
		write_reg(REG_RUN_LEN, run_word);
		write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, 16'($urandom()));
		@(negedge clk);
		cfg_we <= 1'b0;
		calm = $urandom_range(0, 3) == 0;
	endtask

	task automatic wait_idle();
		while (poll_queue.size() != 0 || s_tvalid || gesture_expect.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic run_random(input int count);
		while (poll_queue.size() < count)
			add_sequence();
		wait_idle();
	endtask

	initial begin : stimulus
		int k;
		mdl_cfg.tap_max_time = 16'd250;
		mdl_cfg.double_tap_window = 16'd400;
		mdl_cfg.long_press_time = 16'd700;
		mdl_cfg.hold_time = 16'd1500;
		mdl_cfg.stroke_window = 16'd1200;
		mdl_cfg.stroke_run_length = 8'd3;
		contact_on = 1'b0;
		long_done = 1'b0;
		hold_done = 1'b0;
		tap_pending = 1'b0;
		contact_t0 = '0;
		tap_t0 = '0;
		prev_stroke_at = '0;
		zones_touched = '0;
		stroke_run = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Directed polls under the reset settings.
		queue_poll(8'h00, 32'd0);
		queue_poll(8'h01, 32'd100);
		queue_poll(8'h00, 32'd150);
		queue_poll(8'h80, 32'd300);
		queue_poll(8'h00, 32'd320);
		queue_poll(8'h01, 32'd1000);
		queue_poll(8'h01, 32'd1800);
		queue_poll(8'h01, 32'd2600);
		queue_poll(8'h00, 32'd2700);
		queue_poll(8'hFF, 32'd3000);
		queue_poll(8'h00, 32'd3050);
		queue_poll(8'h02, 32'd3500);
		queue_poll(8'h00, 32'd3900);
		queue_poll(8'h03, 32'd4000);
		queue_poll(8'h00, 32'd4100);
		queue_poll(8'h40, 32'd5000);
		queue_poll(8'h00, 32'd5010);
		queue_poll(8'h00, 32'd5500);
		// Time running backwards during a contact.
		queue_poll(8'h04, 32'd6000);
		queue_poll(8'h04, 32'd5000);
		queue_poll(8'h00, 32'd4000);
		queue_poll(8'h00, 32'hFFFF_FFFF);
		queue_poll(8'h00, 32'd4401);
		queue_poll(8'h08, 32'd10000);
		queue_poll(8'h00, 32'd10010);
		queue_poll(8'h30, 32'd10100);
		queue_poll(8'h00, 32'd10500);
		// A contact across the timestamp wrap.
		queue_poll(8'h10, 32'hFFFF_FF00);
		queue_poll(8'h00, 32'h0000_0010);
		now_ms = 32'd2000;
		wait_idle();

		run_random(300);

		apply_config(0, 0, 0, 0, 0, 16'h0000);
		run_random(150);

		apply_config(65535, 65535, 65535, 65535, 65535, 16'hFFFF);
		run_random(150);

		// A long stroke run with repeats disabled drives the run counter to saturation.
		apply_config(100, 100, 65535, 65535, 65535, 16'h5A00);
		for (k = 0; k < 260; k++) begin
			add_contact($urandom_range(0, 50), 1, 1'b1);
			now_ms += $urandom_range(0, 300);
		end
		wait_idle();
		apply_config(250, 400, 700, 1500, 65535, 16'hC3FF);
		add_contact(10, 1, 1'b1);
		run_random(50);

		for (k = 0; k < 3; k++) begin
			if (k == 0)
				apply_config(120, 300, 900, 300, 800, 16'h0002);
			else
				apply_config($urandom_range(0, 600), $urandom_range(0, 800),
					$urandom_range(0, 1500), $urandom_range(0, 2500), $urandom_range(0, 2000),
					{8'($urandom()), 8'($urandom_range(0, 6))});
			run_random(60);
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && gesture_expect.size() == 0) begin
			$display("PASS touch_gesture_classifier");
		end else begin
			$display("FAIL touch_gesture_classifier");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("FAIL touch_gesture_classifier");
		$finish;
	end

endmodule
